### rtl/lpm_pkg.sv
// Letterbox pixel mapper package: field widths, register indexes, reset values,
// layout codes and the pipeline stage records.
// No dependencies.
`default_nettype none

package lpm_pkg;

    localparam int DIM_W    = 12;               // frame size and coordinate width
    localparam int SHIFT_W  = 2;                // chroma subsampling shift width
    localparam int PLANE_W  = 2;
    localparam int LAYOUT_W = 2;
    localparam int FILL_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;
    localparam int LINE_W   = DIM_W + (1 << SHIFT_W) - 1;   // row shifted into luma lines
    localparam int SUM_W    = LINE_W + 1;

    localparam logic [DIM_W-1:0]    RESET_WIDTH  = DIM_W'(768);
    localparam logic [DIM_W-1:0]    RESET_HEIGHT = DIM_W'(576);
    localparam logic [SHIFT_W-1:0]  RESET_SHIFT  = SHIFT_W'(1);
    localparam logic [FILL_W-1:0]   FILL_LUMA    = FILL_W'(0);
    localparam logic [FILL_W-1:0]   FILL_CHROMA  = FILL_W'(8'h7F);

    localparam logic [LAYOUT_W-1:0] LAYOUT_NONE   = LAYOUT_W'(0);
    localparam logic [LAYOUT_W-1:0] LAYOUT_SINGLE = LAYOUT_W'(1);
    localparam logic [LAYOUT_W-1:0] LAYOUT_PLANAR = LAYOUT_W'(2);

    localparam logic [PLANE_W-1:0]  PLANE_LUMA = PLANE_W'(0);
    localparam logic [PLANE_W-1:0]  PLANE_CB   = PLANE_W'(1);
    localparam logic [PLANE_W-1:0]  PLANE_CR   = PLANE_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH   = 3'd0,
        CFG_SOURCE_HEIGHT  = 3'd1,
        CFG_TARGET_WIDTH   = 3'd2,
        CFG_TARGET_HEIGHT  = 3'd3,
        CFG_LAYOUT_KIND    = 3'd4,
        CFG_CHROMA_X_SHIFT = 3'd5,
        CFG_CHROMA_Y_SHIFT = 3'd6
    } t_cfg_idx;

    // decoded item plus frame offsets
    typedef struct packed {
        logic               sel_luma;
        logic               sel_chroma;
        logic [DIM_W-1:0]   x;
        logic [LINE_W-1:0]  luma_line;
        logic [SHIFT_W-1:0] xs;
        logic [SHIFT_W-1:0] ys;
        logic [DIM_W-1:0]   in_line;
        logic [DIM_W-1:0]   in_pix;
        logic [DIM_W-1:0]   in_h;
        logic [DIM_W-1:0]   out_line;
        logic [DIM_W-1:0]   out_pix;
        logic [DIM_W-1:0]   out_w;
    } t_s1;

    // plane-scaled columns, written and line region known
    typedef struct packed {
        logic               written;
        logic               line_copy;
        logic               chroma;
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   o_pix;
        logic [DIM_W-1:0]   o_w;
        logic [DIM_W-1:0]   i_pix;
        logic [LINE_W-1:0]  luma_line;
        logic [DIM_W-1:0]   in_line;
        logic [DIM_W-1:0]   out_line;
        logic [SHIFT_W-1:0] ys;
    } t_s2;

    // final result
    typedef struct packed {
        logic              is_written;
        logic              is_fill;
        logic [FILL_W-1:0] fill_level;
        logic [DIM_W-1:0]  source_x;
        logic [DIM_W-1:0]  source_row;
    } t_s3;

endpackage

`default_nettype wire

### rtl/letterbox_pixel_mapper.sv
// Letterbox pixel mapper: maps each target sample position to fill or a source
// coordinate, centering the source frame in the target frame. Depends on lpm_pkg.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_plane_index, i_target_x, i_target_row
//  output    out        o_out_valid / i_out_stall o_is_written, o_is_fill, o_fill_level,
//                                                 o_source_x, o_source_row
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Three register stages; items enter stage 1 and are presented from stage 3, and one item
// is taken every cycle while o_in_stall is low. Stage 1 decodes the plane and frame offsets,
// stage 2 scales columns and checks the line region, stage 3 (the output register) resolves
// columns and source coordinates. A stall on the output holds each occupied stage with no
// empty stage after it; empty stages still fill. Reset is synchronous, clears the valid bits
// and restores the configuration registers; payload registers are not reset.
`default_nettype none

module letterbox_pixel_mapper (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [lpm_pkg::PLANE_W-1:0]    i_plane_index,
    input  wire logic [lpm_pkg::DIM_W-1:0]      i_target_x,
    input  wire logic [lpm_pkg::DIM_W-1:0]      i_target_row,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_is_written,
    output logic                                o_is_fill,
    output logic [lpm_pkg::FILL_W-1:0]          o_fill_level,
    output logic [lpm_pkg::DIM_W-1:0]           o_source_x,
    output logic [lpm_pkg::DIM_W-1:0]           o_source_row
);

    logic [lpm_pkg::DIM_W-1:0]    r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [lpm_pkg::LAYOUT_W-1:0] r_layout;
    logic [lpm_pkg::SHIFT_W-1:0]  r_xs, r_ys;

    logic         r_v1, r_v2, r_v3;
    lpm_pkg::t_s1 r_s1, n_s1;
    lpm_pkg::t_s2 r_s2, n_s2;
    lpm_pkg::t_s3 r_s3, n_s3;
    logic         w_rdy1, w_rdy2, w_rdy3;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= lpm_pkg::RESET_WIDTH;
            r_src_h  <= lpm_pkg::RESET_HEIGHT;
            r_tgt_w  <= lpm_pkg::RESET_WIDTH;
            r_tgt_h  <= lpm_pkg::RESET_HEIGHT;
            r_layout <= lpm_pkg::LAYOUT_SINGLE;
            r_xs     <= lpm_pkg::RESET_SHIFT;
            r_ys     <= lpm_pkg::RESET_SHIFT;
        end else if (i_cfg_we) begin
            case (lpm_pkg::t_cfg_idx'(i_cfg_index))
                lpm_pkg::CFG_SOURCE_WIDTH:   r_src_w  <= i_cfg_data;
                lpm_pkg::CFG_SOURCE_HEIGHT:  r_src_h  <= i_cfg_data;
                lpm_pkg::CFG_TARGET_WIDTH:   r_tgt_w  <= i_cfg_data;
                lpm_pkg::CFG_TARGET_HEIGHT:  r_tgt_h  <= i_cfg_data;
                lpm_pkg::CFG_LAYOUT_KIND:    r_layout <= i_cfg_data[lpm_pkg::LAYOUT_W-1:0];
                lpm_pkg::CFG_CHROMA_X_SHIFT: r_xs     <= i_cfg_data[lpm_pkg::SHIFT_W-1:0];
                lpm_pkg::CFG_CHROMA_Y_SHIFT: r_ys     <= i_cfg_data[lpm_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    assign w_rdy3     = !r_v3 || !i_out_stall;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    // stage 1: plane decode and centering offsets
    always_comb begin
        logic                            planar;
        logic [lpm_pkg::DIM_W-1:0]       dh;
        logic [lpm_pkg::DIM_W-1:0]       dw;
        logic [lpm_pkg::DIM_W-1:0]       half_h;
        planar = (r_layout == lpm_pkg::LAYOUT_PLANAR);
        n_s1.sel_luma   = (i_plane_index == lpm_pkg::PLANE_LUMA)
                          && (r_layout == lpm_pkg::LAYOUT_SINGLE || planar);
        n_s1.sel_chroma = (i_plane_index == lpm_pkg::PLANE_CB
                          || i_plane_index == lpm_pkg::PLANE_CR) && planar;
        n_s1.x  = i_target_x;
        n_s1.xs = n_s1.sel_chroma ? r_xs : '0;
        n_s1.ys = n_s1.sel_chroma ? r_ys : '0;
        n_s1.luma_line = lpm_pkg::LINE_W'(i_target_row) << n_s1.ys;

        // vertical offsets round up to an even line count
        dh     = (r_tgt_h < r_src_h) ? (r_src_h - r_tgt_h) : (r_tgt_h - r_src_h);
        half_h = (dh >> 1) + lpm_pkg::DIM_W'(1);
        half_h[0] = 1'b0;
        dw     = (r_tgt_w < r_src_w) ? (r_src_w - r_tgt_w) : (r_tgt_w - r_src_w);
        n_s1.in_line  = (r_tgt_h < r_src_h) ? half_h : '0;
        n_s1.out_line = (r_src_h < r_tgt_h) ? half_h : '0;
        n_s1.in_pix   = (r_tgt_w < r_src_w) ? (dw >> 1) : '0;
        n_s1.out_pix  = (r_src_w < r_tgt_w) ? (dw >> 1) : '0;
        n_s1.out_w    = (r_src_w < r_tgt_w) ? r_src_w : r_tgt_w;
        // an odd source height drops its last line
        n_s1.in_h     = {r_src_h[lpm_pkg::DIM_W-1:1], 1'b0};
    end

    // stage 2: scale columns to the plane, check written and line region
    always_comb begin
        logic [lpm_pkg::DIM_W-1:0] pw;
        logic [lpm_pkg::DIM_W:0]   line_end;
        pw = r_tgt_w >> r_s1.xs;
        line_end = {1'b0, r_s1.in_h} + {1'b0, r_s1.out_line};
        n_s2.written   = (r_s1.sel_luma || r_s1.sel_chroma)
                         && (r_s1.luma_line < lpm_pkg::LINE_W'(r_tgt_h))
                         && (r_s1.x < pw);
        n_s2.line_copy = (r_s1.luma_line >= lpm_pkg::LINE_W'(r_s1.out_line))
                         && (r_s1.luma_line < lpm_pkg::LINE_W'(line_end));
        n_s2.chroma    = r_s1.sel_chroma;
        n_s2.x         = r_s1.x;
        n_s2.o_pix     = r_s1.out_pix >> r_s1.xs;
        n_s2.o_w       = r_s1.out_w >> r_s1.xs;
        n_s2.i_pix     = r_s1.in_pix >> r_s1.xs;
        n_s2.luma_line = r_s1.luma_line;
        n_s2.in_line   = r_s1.in_line;
        n_s2.out_line  = r_s1.out_line;
        n_s2.ys        = r_s1.ys;
    end

    // stage 3: column region and source coordinates
    always_comb begin
        logic [lpm_pkg::DIM_W:0]   col_end;
        logic                      col_copy;
        logic                      copy;
        logic [lpm_pkg::SUM_W-1:0] row_sum;
        logic [lpm_pkg::SUM_W-1:0] row_src;
        col_end  = {1'b0, r_s2.o_pix} + {1'b0, r_s2.o_w};
        col_copy = (r_s2.x >= r_s2.o_pix) && ({1'b0, r_s2.x} < col_end);
        copy     = r_s2.written && r_s2.line_copy && col_copy;
        row_sum  = lpm_pkg::SUM_W'(r_s2.luma_line) + lpm_pkg::SUM_W'(r_s2.in_line)
                   - lpm_pkg::SUM_W'(r_s2.out_line);
        row_src  = row_sum >> r_s2.ys;
        n_s3.is_written = r_s2.written;
        n_s3.is_fill    = r_s2.written && !copy;
        n_s3.fill_level = (r_s2.written && r_s2.chroma) ? lpm_pkg::FILL_CHROMA
                                                         : lpm_pkg::FILL_LUMA;
        n_s3.source_x   = copy ? (r_s2.x - r_s2.o_pix + r_s2.i_pix) : '0;
        n_s3.source_row = copy ? row_src[lpm_pkg::DIM_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // payload advances with its valid bit; hold when the next stage cannot take it
    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_s1 <= n_s1;
        if (w_rdy2) r_s2 <= n_s2;
        if (w_rdy3) r_s3 <= n_s3;
    end

    assign o_out_valid  = r_v3;
    assign o_is_written = r_s3.is_written;
    assign o_is_fill    = r_s3.is_fill;
    assign o_fill_level = r_s3.fill_level;
    assign o_source_x   = r_s3.source_x;
    assign o_source_row = r_s3.source_row;

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_written) |-> (!o_is_fill && o_fill_level == '0
            && o_source_x == '0 && o_source_row == '0))
        else $error("unwritten result carries nonzero fields");

    a_fill_no_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_fill) |-> (o_is_written && o_source_x == '0
            && o_source_row == '0))
        else $error("fill result carries a source coordinate");

    a_fill_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fill_level != '0) |->
            (o_is_written && o_fill_level == lpm_pkg::FILL_CHROMA))
        else $error("bad fill level");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && i_out_stall))
        else $error("input stalled with an empty stage");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy2) |=> r_v2)
        else $error("stage 2 item lost under stall");

endmodule

`default_nettype wire
